### src/hac_pkg.sv
// ----------------------------------------------------------------------------
// hac_pkg
// Shared types, register codes and the thermistor curve of the heat alarm
// sample classifier.
// ----------------------------------------------------------------------------
package hac_pkg;

    localparam int CURVE_STORED = 84;
    localparam int LANES        = 8;

    localparam logic [2:0] REG_ALARM_TEMPERATURE  = 3'd0;
    localparam logic [2:0] REG_FAULT_HIGH_LEVEL   = 3'd1;
    localparam logic [2:0] REG_FAULT_LOW_LEVEL    = 3'd2;
    localparam logic [2:0] REG_BATTERY_LOW_LEVEL  = 3'd3;
    localparam logic [2:0] REG_BATTERY_HIGH_LEVEL = 3'd4;

    localparam logic [6:0] ALARM_TEMPERATURE_RST  = 7'd60;
    localparam logic [7:0] FAULT_HIGH_LEVEL_RST   = 8'd250;
    localparam logic [7:0] FAULT_LOW_LEVEL_RST    = 8'd5;
    localparam logic [7:0] BATTERY_LOW_LEVEL_RST  = 8'hB0;
    localparam logic [7:0] BATTERY_HIGH_LEVEL_RST = 8'hB1;

    localparam logic [7:0] ERROR_ALL = 8'hFF;
    localparam logic [2:0] HOT_ALL   = 3'h7;
    localparam logic [2:0] HOT_NONE  = 3'h0;

    localparam logic ACTION_THERMISTOR = 1'b0;
    localparam logic ACTION_BATTERY    = 1'b1;

    typedef struct packed {
        logic [7:0] error_history;
        logic [2:0] hot_history;
        logic       fire_flag;
        logic       fault_flag;
        logic       low_battery_flag;
        logic [6:0] last_degrees;
    } state_rec_t;

    localparam int REC_W = $bits(state_rec_t);

    function automatic logic [7:0] curve_at(input logic [6:0] idx);
        logic [7:0] v;
        case (idx)
            7'd0:  v = 8'd222;  7'd1:  v = 8'd221;  7'd2:  v = 8'd219;  7'd3:  v = 8'd218;
            7'd4:  v = 8'd216;  7'd5:  v = 8'd215;  7'd6:  v = 8'd213;  7'd7:  v = 8'd211;
            7'd8:  v = 8'd209;  7'd9:  v = 8'd207;  7'd10: v = 8'd206;  7'd11: v = 8'd204;
            7'd12: v = 8'd202;  7'd13: v = 8'd200;  7'd14: v = 8'd198;  7'd15: v = 8'd195;
            7'd16: v = 8'd193;  7'd17: v = 8'd191;  7'd18: v = 8'd189;  7'd19: v = 8'd187;
            7'd20: v = 8'd184;  7'd21: v = 8'd182;  7'd22: v = 8'd180;  7'd23: v = 8'd177;
            7'd24: v = 8'd175;  7'd25: v = 8'd172;  7'd26: v = 8'd170;  7'd27: v = 8'd167;
            7'd28: v = 8'd165;  7'd29: v = 8'd162;  7'd30: v = 8'd160;  7'd31: v = 8'd157;
            7'd32: v = 8'd155;  7'd33: v = 8'd152;  7'd34: v = 8'd149;  7'd35: v = 8'd147;
            7'd36: v = 8'd144;  7'd37: v = 8'd142;  7'd38: v = 8'd139;  7'd39: v = 8'd137;
            7'd40: v = 8'd134;  7'd41: v = 8'd131;  7'd42: v = 8'd129;  7'd43: v = 8'd126;
            7'd44: v = 8'd124;  7'd45: v = 8'd121;  7'd46: v = 8'd119;  7'd47: v = 8'd116;
            7'd48: v = 8'd114;  7'd49: v = 8'd111;  7'd50: v = 8'd109;  7'd51: v = 8'd107;
            7'd52: v = 8'd104;  7'd53: v = 8'd102;  7'd54: v = 8'd100;  7'd55: v = 8'd97;
            7'd56: v = 8'd95;   7'd57: v = 8'd93;   7'd58: v = 8'd91;   7'd59: v = 8'd89;
            7'd60: v = 8'd87;   7'd61: v = 8'd85;   7'd62: v = 8'd83;   7'd63: v = 8'd81;
            7'd64: v = 8'd79;   7'd65: v = 8'd77;   7'd66: v = 8'd75;   7'd67: v = 8'd73;
            7'd68: v = 8'd71;   7'd69: v = 8'd69;   7'd70: v = 8'd68;   7'd71: v = 8'd66;
            7'd72: v = 8'd64;   7'd73: v = 8'd63;   7'd74: v = 8'd61;   7'd75: v = 8'd60;
            7'd76: v = 8'd58;   7'd77: v = 8'd57;   7'd78: v = 8'd55;   7'd79: v = 8'd54;
            7'd80: v = 8'd52;   7'd81: v = 8'd51;   7'd82: v = 8'd50;   7'd83: v = 8'd49;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

### src/hac_ram.sv
// ----------------------------------------------------------------------------
// hac_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module hac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### src/heat_alarm_sample_classifier.sv
// ----------------------------------------------------------------------------
// heat_alarm_sample_classifier
// Classifies thermistor and battery readings; state lives in a one-entry RAM.
// ----------------------------------------------------------------------------
// A battery request goes through S_IDLE, S_LOAD and S_FINISH; a thermistor
// request also passes S_WALK, a curve walk that checks 8 entries a cycle.
// One request at a time: S_FINISH waits while the output is stalled, and the
// next is taken the cycle after the result is written to the output register.
// Reset: asynchronous, active low; control and output registers return to their
// defaults and the state record reads as zero until first written back.
module heat_alarm_sample_classifier
    import hac_pkg::*;
#(
    parameter int TABLE_ENTRIES = 84
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       action,
    input  logic [7:0] reading,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] degrees,
    output logic       fire,
    output logic       sensor_fault,
    output logic       battery_low,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int TABLE_N = (TABLE_ENTRIES > CURVE_STORED) ? CURVE_STORED : TABLE_ENTRIES;
    localparam logic [7:0] LAST_IDX = 8'(TABLE_N - 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LOAD   = 2'd1;
    localparam logic [1:0] S_WALK   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [6:0]  alarm_temperature_reg;
    logic [7:0]  fault_high_level_reg, fault_low_level_reg;
    logic [7:0]  battery_low_level_reg, battery_high_level_reg;
    logic        rec_valid_reg;
    logic        action_reg;
    logic [7:0]  reading_reg;
    logic [6:0]  base_reg, base_next;
    state_rec_t  rec_reg, rec_next, rec_mem, rec_final;
    logic [REC_W-1:0] rd_data;
    logic        out_valid_reg;
    logic [6:0]  degrees_reg;
    logic        fire_reg, sensor_fault_reg, battery_low_reg;
    logic        in_fire, out_free, finish;
    logic        hit;
    logic [6:0]  hit_idx;
    logic [7:0]  lane_idx [LANES];
    logic [7:0]  err_shift;
    logic [2:0]  hot_shift;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign finish    = (state_reg == S_FINISH) && out_free;

    hac_ram #(
        .WIDTH (REC_W),
        .DEPTH (1)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (finish),
        .wr_addr (1'b0),
        .wr_data (rec_final),
        .rd_en   (in_fire),
        .rd_addr (1'b0),
        .rd_data (rd_data)
    );

    assign rec_mem = rec_valid_reg ? state_rec_t'(rd_data) : '0;

    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int j = 0; j < LANES; j++)
        begin
            lane_idx[j] = {1'b0, base_reg} + 8'(j);
            if (!hit && (lane_idx[j] <= LAST_IDX) &&
                ((reading_reg >= curve_at(lane_idx[j][6:0])) || (lane_idx[j] == LAST_IDX)))
            begin
                hit     = 1'b1;
                hit_idx = lane_idx[j][6:0];
            end
        end
    end

    always_comb
    begin
        rec_final = rec_reg;
        hot_shift = {rec_reg.hot_history[1:0], (rec_reg.last_degrees > alarm_temperature_reg)};
        if (action_reg == ACTION_THERMISTOR)
        begin
            rec_final.hot_history = hot_shift;
            if (hot_shift == HOT_ALL)
            begin
                rec_final.fire_flag = 1'b1;
            end
            if (hot_shift == HOT_NONE)
            begin
                rec_final.fire_flag = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rec_next   = rec_reg;
        base_next  = base_reg;
        err_shift  = {rec_mem.error_history[6:0],
                      (reading_reg >= fault_high_level_reg) || (reading_reg <= fault_low_level_reg)};
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                rec_next  = rec_mem;
                base_next = '0;
                if (action_reg == ACTION_BATTERY)
                begin
                    if (rec_mem.low_battery_flag)
                    begin
                        if (reading_reg > battery_high_level_reg)
                        begin
                            rec_next.low_battery_flag = 1'b0;
                        end
                    end
                    else if (reading_reg < battery_low_level_reg)
                    begin
                        rec_next.low_battery_flag = 1'b1;
                    end
                    state_next = S_FINISH;
                end
                else
                begin
                    rec_next.error_history = err_shift;
                    if (err_shift == ERROR_ALL)
                    begin
                        rec_next.fault_flag = 1'b1;
                    end
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                base_next = base_reg + 7'(LANES);
                if (hit)
                begin
                    rec_next.last_degrees = hit_idx;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg              <= S_IDLE;
            rec_valid_reg          <= 1'b0;
            out_valid_reg          <= 1'b0;
            degrees_reg            <= '0;
            fire_reg               <= 1'b0;
            sensor_fault_reg       <= 1'b0;
            battery_low_reg        <= 1'b0;
            alarm_temperature_reg  <= ALARM_TEMPERATURE_RST;
            fault_high_level_reg   <= FAULT_HIGH_LEVEL_RST;
            fault_low_level_reg    <= FAULT_LOW_LEVEL_RST;
            battery_low_level_reg  <= BATTERY_LOW_LEVEL_RST;
            battery_high_level_reg <= BATTERY_HIGH_LEVEL_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ALARM_TEMPERATURE:  alarm_temperature_reg  <= cfg_data[6:0];
                    REG_FAULT_HIGH_LEVEL:   fault_high_level_reg   <= cfg_data;
                    REG_FAULT_LOW_LEVEL:    fault_low_level_reg    <= cfg_data;
                    REG_BATTERY_LOW_LEVEL:  battery_low_level_reg  <= cfg_data;
                    REG_BATTERY_HIGH_LEVEL: battery_high_level_reg <= cfg_data;
                    default:                ;
                endcase
            end
            if (finish)
            begin
                rec_valid_reg    <= 1'b1;
                out_valid_reg    <= 1'b1;
                degrees_reg      <= rec_final.last_degrees;
                fire_reg         <= rec_final.fire_flag;
                sensor_fault_reg <= rec_final.fault_flag;
                battery_low_reg  <= rec_final.low_battery_flag;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg  <= rec_next;
        base_reg <= base_next;
        if (in_fire)
        begin
            action_reg  <= action;
            reading_reg <= reading;
        end
    end

    assign out_valid    = out_valid_reg;
    assign degrees      = degrees_reg;
    assign fire         = fire_reg;
    assign sensor_fault = sensor_fault_reg;
    assign battery_low  = battery_low_reg;

endmodule

### src/hac_checker.sv
// ----------------------------------------------------------------------------
// hac_checker
// Port-level assertions for the heat alarm sample classifier.
// ----------------------------------------------------------------------------
module hac_checker
    import hac_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] degrees,
    input logic       fire,
    input logic       sensor_fault,
    input logic       battery_low
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(degrees) && $stable(fire)
            && $stable(sensor_fault) && $stable(battery_low))
        else $error("result changed while stalled");

    a_degrees_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> degrees <= 7'(CURVE_STORED - 1))
        else $error("degrees beyond curve");

    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        sensor_fault |=> sensor_fault)
        else $error("sensor fault cleared");

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while busy");

endmodule

bind heat_alarm_sample_classifier hac_checker u_hac_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .degrees      (degrees),
    .fire         (fire),
    .sensor_fault (sensor_fault),
    .battery_low  (battery_low)
);
